### design/mtfo_pkg.sv
// ----------------------------------------------------------------------------
// mtfo_pkg
// Constants and helper functions for the MT19937 first-outputs pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package mtfo_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned POS_W   = 2;
  localparam int unsigned TDATA_W = 40;

  // Index of the first upper state word taken by the twist.
  localparam int unsigned MT_SHIFT = 397;

  localparam logic [WORD_W-1:0] MT_MULT    = 32'h6c07_8965;
  localparam logic [WORD_W-1:0] MT_UPPER   = 32'h8000_0000;
  localparam logic [WORD_W-1:0] MT_LOWER   = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] MT_MATRIX  = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] MT_TMASK_B = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] MT_TMASK_C = 32'hefc6_0000;

  // One step of the seeding chain; only the low half of the product is kept.
  function automatic logic [WORD_W-1:0] chain_next(input logic [WORD_W-1:0] prev,
                                                   input logic [WORD_W-1:0] idx);
    logic [WORD_W-1:0] mixed;
    begin
      mixed = prev ^ (prev >> 30);
      return WORD_W'(MT_MULT * mixed) + idx;
    end
  endfunction

  function automatic logic [WORD_W-1:0] twist(input logic [WORD_W-1:0] cur,
                                              input logic [WORD_W-1:0] nxt,
                                              input logic [WORD_W-1:0] far);
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] t;
    begin
      y = (cur & MT_UPPER) | (nxt & MT_LOWER);
      t = far ^ (y >> 1);
      if (y[0]) begin
        t = t ^ MT_MATRIX;
      end
      return t;
    end
  endfunction

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] y_in);
    logic [WORD_W-1:0] y;
    begin
      y = y_in;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & MT_TMASK_B);
      y = y ^ ((y << 15) & MT_TMASK_C);
      y = y ^ (y >> 18);
      return y;
    end
  endfunction

endpackage

`default_nettype wire

### design/mt19937_first_outputs.sv
// ----------------------------------------------------------------------------
// mt19937_first_outputs
// Seeds a 32-bit MT19937 per input word and streams its first tempered outputs.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel (s_*) takes one 32-bit seed per word. For every seed the
//   master channel (m_*) returns NUM_OUTPUTS words in order: tdata carries the
//   tempered value and its position in the run, tlast marks the final one.
//   The seeding chain runs through a pipeline of MT_SHIFT + NUM_OUTPUTS
//   stages, one multiply-add per stage after stage 0, so a new seed can
//   enter every cycle while the chain is not frozen. The last stage
//   twists and tempers all words in parallel into a shift-out buffer, which
//   emits one word per cycle while m_tready is high; it takes the next seed
//   only once it is empty or its final word is being taken, so that single
//   output port limits sustained throughput. When the receiver stalls, the
//   output word holds and the whole chain freezes once the last stage holds a
//   seed the buffer cannot yet take; s_tready then drops. Reset empties the
//   pipeline and the output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module mt19937_first_outputs #(
  parameter int unsigned NUM_OUTPUTS = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [mtfo_pkg::WORD_W-1:0]   s_tdata,   // [31:0] seed
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [mtfo_pkg::TDATA_W-1:0]       m_tdata,   // [31:0] value, [33:32] position
  output logic                               m_tlast
);

  localparam int unsigned STAGES = mtfo_pkg::MT_SHIFT + NUM_OUTPUTS;
  localparam int unsigned CNT_W  = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
  localparam int unsigned PAD_W  = mtfo_pkg::TDATA_W - mtfo_pkg::WORD_W - mtfo_pkg::POS_W;

  logic [STAGES-1:0]                v_q;
  logic [mtfo_pkg::WORD_W-1:0]      w_q  [STAGES];
  logic [mtfo_pkg::WORD_W-1:0]      lo_q [STAGES][NUM_OUTPUTS+1];
  logic [mtfo_pkg::WORD_W-1:0]      hi_q [STAGES][NUM_OUTPUTS];

  logic [mtfo_pkg::WORD_W-1:0]      tempered [NUM_OUTPUTS];
  logic [mtfo_pkg::WORD_W-1:0]      sbuf     [NUM_OUTPUTS];
  logic                             sval;
  logic [CNT_W-1:0]                 cnt;
  logic [mtfo_pkg::POS_W-1:0]       pos;

  logic                             last_now;
  logic                             load_ok;
  logic                             adv;
  logic                             load;
  logic                             shift;

  assign last_now = (cnt == CNT_W'(NUM_OUTPUTS - 1));
  assign load_ok  = !sval || (m_tready && last_now);
  assign adv      = !v_q[STAGES-1] || load_ok;
  assign load     = v_q[STAGES-1] && load_ok;
  assign shift    = sval && m_tready;

  assign s_tready = adv;
  assign m_tvalid = sval;
  assign m_tlast  = last_now;
  assign m_tdata  = {{PAD_W{1'b0}}, pos, sbuf[0]};

  // Valid bits move with the chain; the whole pipeline advances together.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[STAGES-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w_q[0] <= s_tdata;
    end
  end

  // Stage s holds chain word s, plus those of the low words 0..NUM_OUTPUTS and
  // of the upper words whose index is below s, all captured as they pass.
  for (genvar s = 1; s < STAGES; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (adv) begin
        w_q[s] <= mtfo_pkg::chain_next(w_q[s-1], mtfo_pkg::WORD_W'(s));
      end
    end

    for (genvar k = 0; k <= NUM_OUTPUTS; k++) begin : g_lo
      if (k == s - 1) begin : g_take
        always_ff @(posedge clk) begin
          if (adv) begin
            lo_q[s][k] <= w_q[s-1];
          end
        end
      end else if (k < s - 1) begin : g_pass
        always_ff @(posedge clk) begin
          if (adv) begin
            lo_q[s][k] <= lo_q[s-1][k];
          end
        end
      end
    end

    for (genvar j = 0; j < NUM_OUTPUTS; j++) begin : g_hi
      if (mtfo_pkg::MT_SHIFT + j == s - 1) begin : g_take
        always_ff @(posedge clk) begin
          if (adv) begin
            hi_q[s][j] <= w_q[s-1];
          end
        end
      end else if (mtfo_pkg::MT_SHIFT + j < s - 1) begin : g_pass
        always_ff @(posedge clk) begin
          if (adv) begin
            hi_q[s][j] <= hi_q[s-1][j];
          end
        end
      end
    end
  end

  // The last upper word is the chain word of the final stage itself.
  for (genvar k = 0; k < NUM_OUTPUTS; k++) begin : g_twist
    if (k == NUM_OUTPUTS - 1) begin : g_end
      assign tempered[k] = mtfo_pkg::temper(mtfo_pkg::twist(
          lo_q[STAGES-1][k], lo_q[STAGES-1][k+1], w_q[STAGES-1]));
    end else begin : g_mid
      assign tempered[k] = mtfo_pkg::temper(mtfo_pkg::twist(
          lo_q[STAGES-1][k], lo_q[STAGES-1][k+1], hi_q[STAGES-1][k]));
    end
  end

  // Output buffer: loaded in parallel, shifted toward entry zero per word.
  for (genvar i = 0; i < NUM_OUTPUTS; i++) begin : g_sbuf
    if (i < NUM_OUTPUTS - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (load) begin
          sbuf[i] <= tempered[i];
        end else if (shift) begin
          sbuf[i] <= sbuf[i+1];
        end
      end
    end else begin : g_top
      always_ff @(posedge clk) begin
        if (load) begin
          sbuf[i] <= tempered[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sval <= 1'b0;
      cnt  <= '0;
      pos  <= '0;
    end else if (load) begin
      sval <= 1'b1;
      cnt  <= '0;
      pos  <= '0;
    end else if (shift) begin
      if (last_now) begin
        sval <= 1'b0;
      end
      cnt <= cnt + 1'b1;
      pos <= pos + 1'b1;
    end
  end

  // A seed in the last stage that cannot be loaded freezes that stage.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (v_q[STAGES-1] && !adv) |=> (v_q[STAGES-1] && $stable(w_q[STAGES-1])))
    else $error("last chain stage changed while stalled");

  // Every run starts at position zero.
  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    load |=> (sval && cnt == '0 && pos == '0))
    else $error("run did not start at position zero");

  // Position field wraps in step with the run counter.
  a_pos_tracks: assert property (@(posedge clk) disable iff (rst)
    sval |-> (pos == mtfo_pkg::POS_W'(cnt)))
    else $error("position out of step with run counter");

  // The final word of a run with nothing waiting leaves the buffer empty.
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (shift && last_now && !v_q[STAGES-1]) |=> !sval)
    else $error("buffer still valid after final word");

endmodule

`default_nettype wire

### dv/mt19937_first_outputs_tb.sv
// ----------------------------------------------------------------------------
// mt19937_first_outputs_tb
// Self-checking bench for the MT19937 first-outputs pipeline: every accepted
// seed is run through a local MT19937 seeding chain, twist and temper, and the
// returned output words are compared in order against those predictions.
// ----------------------------------------------------------------------------

module mt19937_first_outputs_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RUN_LEN     = 4;
  localparam int unsigned LATENCY     = 397 + RUN_LEN;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned HOLD_LEN    = 900;

  localparam logic [31:0] SEED_MULT  = 32'h6c07_8965;
  localparam logic [31:0] HI_BIT     = 32'h8000_0000;
  localparam logic [31:0] LO_BITS    = 32'h7fff_ffff;
  localparam logic [31:0] TWIST_XOR  = 32'h9908_b0df;
  localparam logic [31:0] MASK_B     = 32'h9d2c_5680;
  localparam logic [31:0] MASK_C     = 32'hefc6_0000;
  localparam int unsigned FAR_OFFSET = 397;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  position;
    logic        last;
  } mt_word_t;

  class tempered_word_board;
    mt_word_t pending_words[$];
    int unsigned errors;
    int unsigned words_checked;

    function new();
      errors = 0;
      words_checked = 0;
    endfunction

    function logic [31:0] temper_word(logic [31:0] y_in);
      logic [31:0] y;
      y = y_in;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & MASK_B);
      y = y ^ ((y << 15) & MASK_C);
      y = y ^ (y >> 18);
      return y;
    endfunction

    // Walks the seeding chain far enough to reach the words the twist needs,
    // then queues the tempered outputs of the run.
    function void note_seed(logic [31:0] seed);
      logic [31:0] near_words[RUN_LEN+1];
      logic [31:0] far_words[RUN_LEN];
      logic [31:0] w;
      logic [31:0] y;
      logic [31:0] t;
      mt_word_t    item;
      w = seed;
      near_words[0] = w;
      for (int unsigned i = 1; i < FAR_OFFSET + RUN_LEN; i++) begin
        w = SEED_MULT * (w ^ (w >> 30)) + i;
        if (i <= RUN_LEN) near_words[i] = w;
        if (i >= FAR_OFFSET) far_words[i - FAR_OFFSET] = w;
      end
      for (int k = 0; k < RUN_LEN; k++) begin
        y = (near_words[k] & HI_BIT) | (near_words[k+1] & LO_BITS);
        t = far_words[k] ^ (y >> 1);
        if (y[0]) t = t ^ TWIST_XOR;
        item.value    = temper_word(t);
        item.position = 2'(k);
        item.last     = (k == RUN_LEN - 1);
        pending_words.push_back(item);
      end
    endfunction

    function void check_word(logic [mtfo_pkg::TDATA_W-1:0] data, logic last);
      mt_word_t want;
      if (pending_words.size() == 0) begin
        $display("%0t: output word with none pending: value %h position %0d last %0b",
                 $time, data[31:0], data[33:32], last);
        errors++;
        return;
      end
      want = pending_words.pop_front();
      words_checked++;
      if (data[31:0] !== want.value) begin
        $display("%0t: value mismatch: expected %h, got %h", $time, want.value, data[31:0]);
        errors++;
      end
      if (data[33:32] !== want.position) begin
        $display("%0t: position mismatch: expected %0d, got %0d",
                 $time, want.position, data[33:32]);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last mismatch: expected %0b, got %0b", $time, want.last, last);
        errors++;
      end
      if (data[mtfo_pkg::TDATA_W-1:34] !== '0) begin
        $display("%0t: padding mismatch: expected 0, got %h",
                 $time, data[mtfo_pkg::TDATA_W-1:34]);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return pending_words.size();
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [31:0]                   s_tdata;
  logic                          m_tvalid;
  logic                          m_tready;
  logic [mtfo_pkg::TDATA_W-1:0]  m_tdata;
  logic                          m_tlast;

  tempered_word_board board;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_left;
  int unsigned seeds_sent;
  int unsigned quiet_cycles;
  bit          saw_input_stall;

  mt19937_first_outputs #(.NUM_OUTPUTS(RUN_LEN)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: a long hold-off takes priority over the random stalls.
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else begin
        m_tready = ($urandom_range(99) >= recv_idle_pct);
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_word(m_tdata, m_tlast);
    if (!rst && s_tvalid && !s_tready) saw_input_stall = 1'b1;
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("mt19937_first_outputs verification failed");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_seed(input logic [31:0] seed);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = seed;
    do @(posedge clk); while (!s_tready);
    board.note_seed(seed);
    seeds_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_seeds(input int unsigned count);
    logic [31:0] seed;
    for (int unsigned n = 0; n < count; n++) begin
      case ($urandom_range(9))
        0: seed = $urandom_range(255);
        1: seed = 32'hffff_ffff - $urandom_range(255);
        default: seed = $urandom;
      endcase
      send_seed(seed);
    end
  endtask

  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  initial begin
    logic [31:0] directed_seeds[$];
    board = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    hold_left = 0;
    seeds_sent = 0;
    saw_input_stall = 1'b0;
    send_idle_pct = 19;
    recv_idle_pct = 47;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Zero, all ones, single bits at both ends, alternating patterns and the
    // customary default seed.
    directed_seeds = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h8000_0000,
                       32'h7fff_ffff, 32'hffff_fffe, 32'h0000_1571, 32'haaaa_aaaa,
                       32'h5555_5555, 32'h0000_ffff, 32'hffff_0000, 32'h4000_0000,
                       32'h0000_0002, 32'h1234_5678, 32'h9908_b0df, 32'h6c07_8965};
    foreach (directed_seeds[i]) send_seed(directed_seeds[i]);
    send_random_seeds(45);
    wait_drained();

    send_idle_pct = 47;
    recv_idle_pct = 19;
    send_random_seeds(50);
    wait_drained();

    // The receiver stops for a long stretch while seeds keep coming sparsely;
    // once a second seed reaches the last stage behind a full output buffer
    // the chain freezes and s_tready has to drop.
    send_idle_pct = 95;
    recv_idle_pct = 0;
    hold_left = HOLD_LEN;
    while (hold_left > 0) send_random_seeds(1);
    send_idle_pct = 0;
    send_random_seeds(30);
    wait_drained();

    repeat (LATENCY + 20) @(negedge clk);

    $display("Sent %0d seeds (directed extremes and random) and checked %0d output words.",
             seeds_sent, board.words_checked);
    $display("Idle mixes on both sides, a %0d-cycle receiver hold-off (input stall seen: %0b).",
             HOLD_LEN, saw_input_stall);
    if (board.errors == 0) begin
      $display("mt19937_first_outputs verification clean");
    end else begin
      $display("mt19937_first_outputs verification failed");
    end
    $finish;
  end

endmodule
